FILE: hdl/fpc_pkg.sv
// Shared types, constants and the sine table builder for the camera pose block.
package fpc_pkg;

  localparam int SineTableBitsDef = 8;

  // Pi/2 in Q2.30 and the fraction shift of Q2.30.
  localparam longint HalfPiQ30 = 64'sd1686629713;
  localparam int     Q30Shift  = 30;

  // Divisors (2k)(2k+1) of the odd Taylor terms of sine, k = 1 to 7.
  localparam longint TaylorDiv [7] = '{64'sd6, 64'sd20, 64'sd42, 64'sd72,
                                       64'sd110, 64'sd156, 64'sd210};

  localparam logic [15:0] QuarterTurn = 16'h4000;

  typedef enum logic [2:0] {
    CmdPitch   = 3'd0,
    CmdYaw     = 3'd1,
    CmdForward = 3'd2,
    CmdStrafe  = 3'd3,
    CmdMove    = 3'd4
  } cmd_e;

  // One quarter-wave table entry in Q1.15, built at elaboration time.
  function automatic logic [14:0] sine_entry(int idx, int tab_bits);
    longint x;
    longint x2;
    longint term;
    longint sum;
    longint e;
    x    = (HalfPiQ30 * longint'(idx)) >>> tab_bits;
    x2   = (x * x) >>> Q30Shift;
    term = x;
    sum  = x;
    for (int k = 1; k <= 7; k++) begin
      term = ((term * x2) >>> Q30Shift) / TaylorDiv[k-1];
      if ((k & 1) != 0) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    e = (sum * 64'sd32767 + (64'sd1 <<< (Q30Shift - 1))) >>> Q30Shift;
    if (e > 64'sd32767) begin
      e = 64'sd32767;
    end
    return e[14:0];
  endfunction

endpackage

FILE: hdl/fpc_sine.sv
// Quarter-wave sine lookup in Q1.15 for a 16-bit binary angle.
module fpc_sine import fpc_pkg::*; #(
  parameter int SINE_TABLE_BITS = SineTableBitsDef
) (
  input  logic        [15:0] angle_i,
  output logic signed [15:0] sine_o
);

  localparam int TabN = 1 << SINE_TABLE_BITS;

  logic [14:0]              rom [TabN+1];
  logic [1:0]               quad;
  logic [SINE_TABLE_BITS:0] idx;
  logic [SINE_TABLE_BITS:0] addr;
  logic [14:0]              mag;

  for (genvar g = 0; g <= TabN; g++) begin : g_rom
    assign rom[g] = sine_entry(g, SINE_TABLE_BITS);
  end

  assign quad = angle_i[15:14];
  assign idx  = {1'b0, angle_i[13:14-SINE_TABLE_BITS]};

  // Odd quadrants run the table backward; the lower half plane negates.
  assign addr   = quad[0] ? ((SINE_TABLE_BITS+1)'(TabN) - idx) : idx;
  assign mag    = rom[addr];
  assign sine_o = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

FILE: hdl/fpc_mul.sv
// Shared signed 32 by 32 multiplier with a registered product.
module fpc_mul import fpc_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [63:0] prod_o
);

  logic signed [63:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign prod_o = prod_q;

endmodule

FILE: hdl/first_person_camera_pose.sv
// Top level of the first-person camera pose keeper: sequencer, saturating adder and pose state.
//
// Input channel: command_i with angle_step_i, distance_i and move_*_i is taken
// when in_valid_i is high and in_stall_o is low. Output channel: the pose
// after each command (position, yaw, pitch, saturated flag) is offered with
// out_valid_o and held until a cycle in which out_stall_i is low.
// One item is in work at a time; in_stall_o stays high from acceptance until
// the result is loaded into the output register.
// A forward or strafe move uses the shared multiplier for two trig products
// and then one product per position component (y is skipped in a strafe);
// each component product is rounded and added to the position with
// saturation. A vector move adds its components without the multiplier.
// A finished result waits in the output register while the receiver stalls;
// the next item may be accepted then, but its result is not loaded until the
// waiting one has been taken.
// Reset clears the position and both angles to zero and drops out_valid_o.
module first_person_camera_pose import fpc_pkg::*; #(
  parameter int SINE_TABLE_BITS = SineTableBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic        [2:0]  command_i,
  input  logic signed [15:0] angle_step_i,
  input  logic signed [31:0] distance_i,
  input  logic signed [31:0] move_x_i,
  input  logic signed [31:0] move_y_i,
  input  logic signed [31:0] move_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] pos_x_out_o,
  output logic signed [31:0] pos_y_out_o,
  output logic signed [31:0] pos_z_out_o,
  output logic        [15:0] yaw_out_o,
  output logic        [15:0] pitch_out_o,
  output logic               saturated_o
);

  typedef enum logic [2:0] {
    StIdle,
    StTrig,
    StMul,
    StAcc,
    StDone
  } state_e;

  state_e             state_q;
  logic [2:0]         cmd_q;
  logic [2:0]         step_q;
  logic signed [31:0] dist_q;
  logic signed [31:0] mv_q [3];
  logic signed [31:0] pos_q [3];
  logic [15:0]        yaw_q;
  logic [15:0]        pitch_q;
  logic               sat_q;
  logic signed [15:0] sy_q, cy_q, sp_q, cp_q;
  logic signed [31:0] dx_q, dz_q;

  logic               out_valid_q;
  logic signed [31:0] out_x_q, out_y_q, out_z_q;
  logic [15:0]        out_yaw_q, out_pitch_q;
  logic               out_sat_q;

  logic signed [15:0] sy, cy, sp, cp;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic               is_strafe;
  logic               flip;
  logic [1:0]         comp;
  logic               neg;
  logic [63:0]        mag;
  logic [62:0]        mag_rnd;
  logic [32:0]        rnd;
  logic signed [33:0] delta;
  logic signed [34:0] sum_d;
  logic signed [31:0] pos_d;
  logic               clip_d;
  logic               out_free;
  logic [2:0]         step_d;

  fpc_sine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_sin_yaw (
    .angle_i(yaw_q), .sine_o(sy));
  fpc_sine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_cos_yaw (
    .angle_i(yaw_q + QuarterTurn), .sine_o(cy));
  fpc_sine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_sin_pitch (
    .angle_i(pitch_q), .sine_o(sp));
  fpc_sine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_cos_pitch (
    .angle_i(pitch_q + QuarterTurn), .sine_o(cp));

  assign is_strafe = (cmd_q == CmdStrafe);

  // Steps 0 and 1 form the horizontal direction terms, steps 2 to 4 scale
  // the direction by the distance for x, y and z.
  always_comb begin
    mul_a = '0;
    mul_b = dist_q;
    case (step_q)
      3'd0: begin
        mul_a = 32'(sy_q);
        mul_b = 32'(cp_q);
      end
      3'd1: begin
        mul_a = 32'(cy_q);
        mul_b = 32'(cp_q);
      end
      3'd2: mul_a = is_strafe ? dz_q : dx_q;
      3'd3: mul_a = {{1{sp_q[15]}}, sp_q, 15'd0};
      3'd4: mul_a = is_strafe ? dx_q : dz_q;
      default: mul_a = '0;
    endcase
  end

  fpc_mul u_mul (
    .clk_i (clk_i),
    .en_i  (state_q == StMul),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .prod_o(prod)
  );

  // The model scales by minus the distance everywhere except the z term of
  // a strafe; rounding is symmetric, so the sign is applied after rounding.
  assign flip    = !is_strafe || (step_q == 3'd2);
  assign comp    = 2'(step_q - 3'd2);
  assign neg     = prod[63];
  assign mag     = neg ? 64'(-prod) : 64'(prod);
  assign mag_rnd = mag[62:0] + (63'd1 << (Q30Shift - 1));
  assign rnd     = mag_rnd[62:30];

  always_comb begin
    if (cmd_q == CmdMove) begin
      delta = 34'(mv_q[comp]);
    end else if (neg ^ flip) begin
      delta = -$signed({1'b0, rnd});
    end else begin
      delta = $signed({1'b0, rnd});
    end
    sum_d  = 35'(pos_q[comp]) + 35'(delta);
    clip_d = (sum_d[34:31] != {4{sum_d[31]}});
    if (!clip_d) begin
      pos_d = sum_d[31:0];
    end else if (sum_d[34]) begin
      pos_d = 32'sh8000_0000;
    end else begin
      pos_d = 32'sh7fff_ffff;
    end
  end

  // The y step is skipped in a strafe.
  assign step_d   = (is_strafe && step_q == 3'd2) ? 3'd4 : step_q + 3'd1;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cmd_q       <= '0;
      step_q      <= '0;
      pos_q[0]    <= '0;
      pos_q[1]    <= '0;
      pos_q[2]    <= '0;
      yaw_q       <= '0;
      pitch_q     <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // A result loaded in the done state keeps the output valid.
      if (out_valid_q && !out_stall_i && state_q != StDone) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            cmd_q   <= command_i;
            dist_q  <= distance_i;
            mv_q[0] <= move_x_i;
            mv_q[1] <= move_y_i;
            mv_q[2] <= move_z_i;
            sat_q   <= 1'b0;
            case (command_i)
              CmdPitch: begin
                pitch_q <= pitch_q + angle_step_i;
                state_q <= StDone;
              end
              CmdYaw: begin
                yaw_q   <= yaw_q + angle_step_i;
                state_q <= StDone;
              end
              CmdForward, CmdStrafe: begin
                step_q  <= 3'd0;
                state_q <= StTrig;
              end
              CmdMove: begin
                step_q  <= 3'd2;
                state_q <= StAcc;
              end
              default: state_q <= StDone;
            endcase
          end
        end
        StTrig: begin
          sy_q    <= sy;
          cy_q    <= cy;
          sp_q    <= sp;
          cp_q    <= cp;
          state_q <= StMul;
        end
        StMul: begin
          state_q <= StAcc;
        end
        StAcc: begin
          if (step_q == 3'd0) begin
            dx_q <= -prod[31:0];
          end else if (step_q == 3'd1) begin
            dz_q <= -prod[31:0];
          end else begin
            pos_q[comp] <= pos_d;
            sat_q       <= sat_q | clip_d;
          end
          step_q <= step_d;
          if (step_q == 3'd4) begin
            state_q <= StDone;
          end else if (cmd_q == CmdMove) begin
            state_q <= StAcc;
          end else begin
            state_q <= StMul;
          end
        end
        StDone: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_x_q     <= pos_q[0];
            out_y_q     <= pos_q[1];
            out_z_q     <= pos_q[2];
            out_yaw_q   <= yaw_q;
            out_pitch_q <= pitch_q;
            out_sat_q   <= sat_q;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign pos_x_out_o = out_x_q;
  assign pos_y_out_o = out_y_q;
  assign pos_z_out_o = out_z_q;
  assign yaw_out_o   = out_yaw_q;
  assign pitch_out_o = out_pitch_q;
  assign saturated_o = out_sat_q;

endmodule

FILE: tb/first_person_camera_pose_tb.sv
// Self-checking testbench for the first-person camera pose keeper.
`timescale 1ns / 1ps

module first_person_camera_pose_tb;
  import fpc_pkg::*;

  localparam int LutBits = SineTableBitsDef;
  localparam int LutSize = 1 << LutBits;
  localparam longint QuarterTurnRadQ30 = 64'sd1686629713;
  localparam longint OneQ30 = 64'sd1073741824;
  localparam logic [2:0] FirstReservedCmd = 3'd5;
  localparam logic [2:0] LastReservedCmd = 3'd7;
  localparam int RandomCommands = 950;
  localparam int CycleLimit = 600000;
  localparam int DrainCycles = 20;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [15:0] yaw;
    logic [15:0] pitch;
    logic sat;
  } pose_t;

  // Keeps its own copy of the camera state and the poses still owed by the block.
  class camera_pose_book;
    int sine_lut[LutSize + 1];
    logic signed [31:0] px, py, pz;
    logic [15:0] yaw, pitch;
    pose_t expected_poses[$];
    int mismatches;
    int by_cmd[8];
    int clipped;

    function new();
      longint x, x2, term, sum, e;
      for (int i = 0; i <= LutSize; i++) begin
        x = (QuarterTurnRadQ30 * i) / LutSize;
        x2 = (x * x) / OneQ30;
        term = x;
        sum = x;
        for (int k = 1; k <= 7; k++) begin
          term = ((term * x2) / OneQ30) / longint'((2 * k) * (2 * k + 1));
          if (k % 2 == 1) begin
            sum = sum - term;
          end else begin
            sum = sum + term;
          end
        end
        if (sum < 0) sum = 0;
        e = (sum * 32767 + OneQ30 / 2) / OneQ30;
        if (e > 32767) e = 32767;
        sine_lut[i] = int'(e);
      end
      px = '0;
      py = '0;
      pz = '0;
      yaw = '0;
      pitch = '0;
      mismatches = 0;
      clipped = 0;
    endfunction

    function int sin_q15(logic [15:0] a);
      int idx;
      int v;
      idx = int'(a[13:0] >> (14 - LutBits));
      v = a[14] ? sine_lut[LutSize - idx] : sine_lut[idx];
      return a[15] ? -v : v;
    endfunction

    // Product scaled down by 2^30, rounded to nearest with ties away from zero.
    function longint round_q30(longint a, longint b);
      longint p;
      longint mag;
      p = a * b;
      mag = (p < 0) ? -p : p;
      mag = (mag + (64'sd1 <<< 29)) >>> 30;
      return (p < 0) ? -mag : mag;
    endfunction

    function logic signed [31:0] clip_add(logic signed [31:0] p, longint d, inout logic sat);
      longint s;
      s = longint'(p) + d;
      if (s > 64'sd2147483647) begin
        sat = 1'b1;
        return 32'sh7FFF_FFFF;
      end
      if (s < -64'sd2147483648) begin
        sat = 1'b1;
        return 32'sh8000_0000;
      end
      return s[31:0];
    endfunction

    function void note_command(logic [2:0] cmd, logic [15:0] step, logic signed [31:0] travel,
                               logic signed [31:0] mx, logic signed [31:0] my,
                               logic signed [31:0] mz);
      longint sy, cy, sp, cp, dx, dy, dz, d;
      pose_t nxt;
      nxt.sat = 1'b0;
      d = travel;
      by_cmd[cmd]++;
      case (cmd)
        CmdPitch: pitch = pitch + step;
        CmdYaw: yaw = yaw + step;
        CmdForward, CmdStrafe: begin
          sy = sin_q15(yaw);
          cy = sin_q15(yaw + QuarterTurn);
          sp = sin_q15(pitch);
          cp = sin_q15(pitch + QuarterTurn);
          dx = -(sy * cp);
          dy = sp * 32768;
          dz = -(cy * cp);
          if (cmd == CmdForward) begin
            px = clip_add(px, round_q30(dx, -d), nxt.sat);
            py = clip_add(py, round_q30(dy, -d), nxt.sat);
            pz = clip_add(pz, round_q30(dz, -d), nxt.sat);
          end else begin
            // Sideways motion stays in the horizontal plane.
            px = clip_add(px, round_q30(dz, -d), nxt.sat);
            pz = clip_add(pz, round_q30(dx, d), nxt.sat);
          end
        end
        CmdMove: begin
          px = clip_add(px, longint'(mx), nxt.sat);
          py = clip_add(py, longint'(my), nxt.sat);
          pz = clip_add(pz, longint'(mz), nxt.sat);
        end
        default: ;
      endcase
      if (nxt.sat) clipped++;
      nxt.px = px;
      nxt.py = py;
      nxt.pz = pz;
      nxt.yaw = yaw;
      nxt.pitch = pitch;
      expected_poses.push_back(nxt);
    endfunction

    function void compare_field(string label, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t ns: %s mismatch, expected %h actual %h", $time, label, want, got);
      end
    endfunction

    function void check_pose(pose_t got);
      pose_t want;
      if (expected_poses.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected pose item, expected none actual x=%h y=%h z=%h",
                 $time, got.px, got.py, got.pz);
        return;
      end
      want = expected_poses.pop_front();
      compare_field("pos_x", want.px, got.px);
      compare_field("pos_y", want.py, got.py);
      compare_field("pos_z", want.pz, got.pz);
      compare_field("yaw", {16'h0, want.yaw}, {16'h0, got.yaw});
      compare_field("pitch", {16'h0, want.pitch}, {16'h0, got.pitch});
      compare_field("saturated", {31'h0, want.sat}, {31'h0, got.sat});
    endfunction

    function int pending();
      return expected_poses.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic [2:0] command_i;
  logic signed [15:0] angle_step_i;
  logic signed [31:0] distance_i;
  logic signed [31:0] move_x_i;
  logic signed [31:0] move_y_i;
  logic signed [31:0] move_z_i;
  logic out_valid_o;
  logic out_stall_i;
  logic signed [31:0] pos_x_out_o;
  logic signed [31:0] pos_y_out_o;
  logic signed [31:0] pos_z_out_o;
  logic [15:0] yaw_out_o;
  logic [15:0] pitch_out_o;
  logic saturated_o;

  camera_pose_book book = new();
  int cycle_count = 0;
  int stall_left = 0;
  bit no_gaps = 1'b0;

  first_person_camera_pose u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .command_i(command_i),
    .angle_step_i(angle_step_i),
    .distance_i(distance_i),
    .move_x_i(move_x_i),
    .move_y_i(move_y_i),
    .move_z_i(move_z_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .pos_x_out_o(pos_x_out_o),
    .pos_y_out_o(pos_y_out_o),
    .pos_z_out_o(pos_z_out_o),
    .yaw_out_o(yaw_out_o),
    .pitch_out_o(pitch_out_o),
    .saturated_o(saturated_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d poses outstanding", cycle_count,
               book.pending());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver back-pressure: calm stretches, short random stalls and a few long holds.
  always @(posedge clk_i) begin : stall_gen
    int pick;
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (cycle_count % 1500 < 300) begin
      out_stall_i <= 1'b0;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        stall_left = $urandom_range(8, 40);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= (pick < 30);
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    pose_t got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        book.note_command(command_i, angle_step_i, distance_i, move_x_i, move_y_i, move_z_i);
      end
      if (out_valid_o && !out_stall_i) begin
        got.px = pos_x_out_o;
        got.py = pos_y_out_o;
        got.pz = pos_z_out_o;
        got.yaw = yaw_out_o;
        got.pitch = pitch_out_o;
        got.sat = saturated_o;
        book.check_pose(got);
      end
    end
  end

  // Offers one item, holds it until taken, then idles for a random gap unless no_gaps is set.
  task automatic issue(logic [2:0] cmd, logic [15:0] step, logic [31:0] travel,
                       logic [31:0] mx, logic [31:0] my, logic [31:0] mz);
    int gap;
    in_valid_i <= 1'b1;
    command_i <= cmd;
    angle_step_i <= step;
    distance_i <= travel;
    move_x_i <= mx;
    move_y_i <= my;
    move_z_i <= mz;
    do @(posedge clk_i); while (in_stall_o);
    if (no_gaps) begin
      gap = 0;
    end else if ($urandom_range(0, 9) == 0) begin
      gap = $urandom_range(8, 40);
    end else begin
      gap = $urandom_range(0, 2);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] rand_q16();
    logic [31:0] v;
    if ($urandom_range(0, 99) < 15) begin
      v = $urandom;
    end else begin
      v = $urandom_range(0, 32'h001F_FFFF);
      if ($urandom_range(0, 1) == 1) v = -v;
    end
    return v;
  endfunction

  initial begin : stimulus
    int pick;
    logic [2:0] cmd;
    logic [15:0] step;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    command_i <= CmdPitch;
    angle_step_i <= '0;
    distance_i <= '0;
    move_x_i <= '0;
    move_y_i <= '0;
    move_z_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: axis moves at zero pose, angle extremes and wrap, looking straight up,
    // full-scale travel, clipping both ways, and the reserved codes.
    issue(CmdForward, 16'h0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
    issue(CmdStrafe, 16'h0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
    issue(CmdYaw, 16'h4000, 32'h0, 32'h0, 32'h0, 32'h0);
    issue(CmdForward, 16'h0000, 32'h0003_8000, 32'h0, 32'h0, 32'h0);
    issue(CmdPitch, 16'h7FFF, 32'h0, 32'h0, 32'h0, 32'h0);
    issue(CmdPitch, 16'h8000, 32'h0, 32'h0, 32'h0, 32'h0);
    issue(CmdYaw, 16'h8000, 32'h0, 32'h0, 32'h0, 32'h0);
    issue(CmdYaw, 16'hFFFF, 32'h0, 32'h0, 32'h0, 32'h0);
    issue(CmdPitch, 16'h4001, 32'h0, 32'h0, 32'h0, 32'h0);
    issue(CmdStrafe, 16'h0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0);
    issue(CmdForward, 16'h0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0);
    issue(CmdForward, 16'h0000, 32'h8000_0000, 32'h0, 32'h0, 32'h0);
    issue(CmdPitch, 16'hC000, 32'h0, 32'h0, 32'h0, 32'h0);
    issue(CmdForward, 16'h0000, 32'h0000_0000, 32'h0, 32'h0, 32'h0);
    issue(CmdMove, 16'h0000, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    issue(CmdMove, 16'h0000, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    issue(CmdMove, 16'h0000, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    issue(CmdMove, 16'h0000, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    issue(CmdMove, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h0);
    issue(CmdStrafe, 16'h0000, 32'h8000_0000, 32'h0, 32'h0, 32'h0);
    for (int c = FirstReservedCmd; c <= LastReservedCmd; c++) begin
      issue(3'(c), 16'h7FFF, 32'h1234_5678, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    end
    issue(CmdYaw, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h0);

    for (int n = 0; n < RandomCommands; n++) begin
      no_gaps = ((n / 60) % 4 == 3);
      pick = $urandom_range(0, 99);
      if (pick < 20) cmd = CmdPitch;
      else if (pick < 40) cmd = CmdYaw;
      else if (pick < 65) cmd = CmdForward;
      else if (pick < 85) cmd = CmdStrafe;
      else if (pick < 95) cmd = CmdMove;
      else cmd = 3'($urandom_range(FirstReservedCmd, LastReservedCmd));
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        step = 16'($urandom);
      end else if (pick < 40) begin
        step = {2'($urandom_range(0, 3)), 14'h0};
      end else begin
        step = 16'($urandom_range(0, 2048));
        if ($urandom_range(0, 1) == 1) step = -step;
      end
      issue(cmd, step, rand_q16(), rand_q16(), rand_q16(), rand_q16());
    end
    in_valid_i <= 1'b0;

    while (book.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Commands: %0d pitch, %0d yaw, %0d forward, %0d strafe, %0d vector, %0d reserved",
             book.by_cmd[CmdPitch], book.by_cmd[CmdYaw], book.by_cmd[CmdForward],
             book.by_cmd[CmdStrafe], book.by_cmd[CmdMove],
             book.by_cmd[5] + book.by_cmd[6] + book.by_cmd[7]);
    $display("Clipped poses: %0d, field mismatches: %0d", book.clipped, book.mismatches);
    if (book.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
